/* hw/rtl/stbs_pkg.sv */
package stbs_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic KIND_ELEMENT = 1'b0;
  localparam logic KIND_ANSWER  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_START,
    ST_SORT_GETV,
    ST_SORT_CMP,
    ST_SORT_PLACE,
    ST_EMIT_READ,
    ST_EMIT_PUT,
    ST_SRCH_READ,
    ST_SRCH_CMP,
    ST_SRCH_PUT
  } state_t;

endpackage

/* hw/rtl/stbs_in_if.sv */
interface stbs_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [stbs_pkg::VALUE_W-1:0] value;
  logic                                last;

  modport source (output valid, output command, output value, output last, input ready);
  modport sink   (input valid, input command, input value, input last, output ready);
endinterface

/* hw/rtl/stbs_out_if.sv */
interface stbs_out_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [stbs_pkg::VALUE_W-1:0] value_res;
  logic        [stbs_pkg::POS_W-1:0]   position;
  logic                                found;
  logic                                overflow;
  logic                                last_res;

  modport source (output valid, output kind, output value_res, output position,
                  output found, output overflow, output last_res, input ready);
  modport sink   (input valid, input kind, input value_res, input position,
                  input found, input overflow, input last_res, output ready);
endinterface

/* hw/rtl/stbs_mem.sv */
module stbs_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic        [ADDR_W-1:0] waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic        [ADDR_W-1:0] raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= store[raddr];
  end

endmodule

/* hw/rtl/stbs_core.sv */
module stbs_core #(
  parameter int CAPACITY = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  stbs_in_if.sink                               din,
  stbs_out_if.source                            dout,
  output logic                                  mem_we,
  output logic        [$clog2(CAPACITY)-1:0]    mem_waddr,
  output logic signed [stbs_pkg::VALUE_W-1:0]   mem_wdata,
  output logic        [$clog2(CAPACITY)-1:0]    mem_raddr,
  input  logic signed [stbs_pkg::VALUE_W-1:0]   mem_rdata
);
  import stbs_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  state_t state, state_next;

  logic [CNT_W-1:0]  count, count_next;
  logic              set_sorted, set_sorted_next;
  logic              overflow_seen, overflow_seen_next;

  // insertion sort pointers
  logic [CNT_W-1:0]          i, i_next;
  logic [ADDR_W-1:0]         j, j_next;
  logic signed [VALUE_W-1:0] v, v_next;

  logic [CNT_W-1:0] k, k_next;

  // search window is [lo, hix)
  logic [CNT_W-1:0]          lo, lo_next;
  logic [CNT_W-1:0]          hix, hix_next;
  logic [ADDR_W-1:0]         mid, mid_next;
  logic [CNT_W:0]            mid_sum;
  logic signed [VALUE_W-1:0] key, key_next;
  logic                      hit, hit_next;
  logic [ADDR_W-1:0]         hit_pos, hit_pos_next;

  logic                      out_valid;
  logic                      out_free;
  logic                      out_load;
  logic                      nxt_kind;
  logic signed [VALUE_W-1:0] nxt_value;
  logic [POS_W-1:0]          nxt_position;
  logic                      nxt_found;
  logic                      nxt_last;

  logic             in_acc;
  logic [CNT_W-1:0] eff_count;

  assign out_free  = !out_valid || dout.ready;
  assign din.ready = (state == ST_IDLE);
  assign in_acc    = din.valid && din.ready;
  assign eff_count = set_sorted ? '0 : count;
  assign mid_sum   = {1'b0, lo} + {1'b0, hix} - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      set_sorted    <= 1'b0;
      overflow_seen <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      set_sorted    <= set_sorted_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    i       <= i_next;
    j       <= j_next;
    v       <= v_next;
    k       <= k_next;
    lo      <= lo_next;
    hix     <= hix_next;
    mid     <= mid_next;
    key     <= key_next;
    hit     <= hit_next;
    hit_pos <= hit_pos_next;
  end

  always_comb begin
    state_next         = state;
    count_next         = count;
    set_sorted_next    = set_sorted;
    overflow_seen_next = overflow_seen;
    i_next             = i;
    j_next             = j;
    v_next             = v;
    k_next             = k;
    lo_next            = lo;
    hix_next           = hix;
    mid_next           = mid;
    key_next           = key;
    hit_next           = hit;
    hit_pos_next       = hit_pos;
    mem_we             = 1'b0;
    mem_waddr          = '0;
    mem_wdata          = din.value;
    mem_raddr          = '0;
    out_load           = 1'b0;
    nxt_kind           = KIND_ELEMENT;
    nxt_value          = mem_rdata;
    nxt_position       = POS_W'(k);
    nxt_found          = 1'b0;
    nxt_last           = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (din.command == CMD_LOAD) begin
            // a load after a finished set starts a new one
            overflow_seen_next = set_sorted ? 1'b0 : overflow_seen;
            set_sorted_next    = 1'b0;
            count_next         = eff_count;
            if (eff_count < CNT_W'(CAPACITY)) begin
              mem_we     = 1'b1;
              mem_waddr  = eff_count[ADDR_W-1:0];
              count_next = eff_count + 1'b1;
            end else begin
              overflow_seen_next = 1'b1;
            end
            if (din.last) begin
              set_sorted_next = 1'b1;
              i_next          = CNT_W'(1);
              state_next      = ST_SORT_START;
            end
          end else begin
            key_next     = din.value;
            hit_next     = 1'b0;
            hit_pos_next = '0;
            lo_next      = '0;
            hix_next     = count;
            state_next   = (set_sorted && count != '0) ? ST_SRCH_READ : ST_SRCH_PUT;
          end
        end
      end

      ST_SORT_START: begin
        if (i >= count) begin
          k_next     = '0;
          state_next = ST_EMIT_READ;
        end else begin
          mem_raddr  = i[ADDR_W-1:0];
          j_next     = i[ADDR_W-1:0];
          state_next = ST_SORT_GETV;
        end
      end

      ST_SORT_GETV: begin
        v_next     = mem_rdata;
        mem_raddr  = j - 1'b1;
        state_next = ST_SORT_CMP;
      end

      ST_SORT_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = j;
        if (mem_rdata > v) begin
          // shift the larger element up one slot, then look one further down
          mem_wdata = mem_rdata;
          j_next    = j - 1'b1;
          if (j == ADDR_W'(1)) begin
            state_next = ST_SORT_PLACE;
          end else begin
            mem_raddr = j - ADDR_W'(2);
          end
        end else begin
          mem_wdata  = v;
          i_next     = i + 1'b1;
          state_next = ST_SORT_START;
        end
      end

      ST_SORT_PLACE: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = v;
        i_next     = i + 1'b1;
        state_next = ST_SORT_START;
      end

      ST_EMIT_READ: begin
        mem_raddr  = k[ADDR_W-1:0];
        state_next = ST_EMIT_PUT;
      end

      ST_EMIT_PUT: begin
        // keep the address so read data holds while the output is stalled
        mem_raddr = k[ADDR_W-1:0];
        nxt_last  = (k + 1'b1 == count);
        if (out_free) begin
          out_load = 1'b1;
          if (nxt_last) begin
            state_next = ST_IDLE;
          end else begin
            k_next     = k + 1'b1;
            state_next = ST_EMIT_READ;
          end
        end
      end

      ST_SRCH_READ: begin
        if (lo < hix) begin
          mem_raddr  = mid_sum[ADDR_W:1];
          mid_next   = mid_sum[ADDR_W:1];
          state_next = ST_SRCH_CMP;
        end else begin
          state_next = ST_SRCH_PUT;
        end
      end

      ST_SRCH_CMP: begin
        if (mem_rdata == key) begin
          hit_next     = 1'b1;
          hit_pos_next = mid;
          state_next   = ST_SRCH_PUT;
        end else begin
          if (key < mem_rdata) begin
            hix_next = CNT_W'(mid);
          end else begin
            lo_next = CNT_W'(mid) + 1'b1;
          end
          state_next = ST_SRCH_READ;
        end
      end

      ST_SRCH_PUT: begin
        nxt_kind     = KIND_ANSWER;
        nxt_value    = key;
        nxt_position = POS_W'(hit_pos);
        nxt_found    = hit;
        nxt_last     = 1'b1;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dout.kind      <= nxt_kind;
      dout.value_res <= nxt_value;
      dout.position  <= nxt_position;
      dout.found     <= nxt_found;
      dout.overflow  <= overflow_seen;
      dout.last_res  <= nxt_last;
    end
  end

  assign dout.valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count beyond capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || dout.ready))
    else $error("output register loaded while a result is held");

  a_last_load_sorts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && din.command == CMD_LOAD && din.last) |=>
      (set_sorted && state == ST_SORT_START))
    else $error("last load did not start the sort");

  a_shift_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT_CMP) |-> (j != '0))
    else $error("insertion compare at slot zero");

  a_hit_needs_set: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_PUT && hit) |-> (set_sorted && CNT_W'(hit_pos) < count))
    else $error("search hit outside the sorted set");

endmodule

/* hw/rtl/sort_then_binary_search.sv */
// Loads use command 0; the load marked last starts an in-place insertion sort
// over the single-port-read element memory for the n stored elements, shifting
// each larger element up one slot in turn, and is followed by the n sorted
// elements, ordered ascending with the final one flagged. A search (command 1)
// runs its binary-search probes one after another; each probe waits on the
// registered memory read. Input ready is low while a sort, the element stream or
// a search is in progress; a result held in the output register does not block
// the next request. Loads past CAPACITY are dropped and set the overflow flag of
// the set.
module sort_then_binary_search #(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst,
  stbs_in_if.sink    din,
  stbs_out_if.source dout
);
  import stbs_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);

  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]         mem_raddr;
  logic signed [VALUE_W-1:0] mem_rdata;

  stbs_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W),
    .DATA_W (VALUE_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  stbs_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .dout      (dout),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import stbs_pkg::*;

  localparam int CAPACITY = 64;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int PHASE_ITEMS = 84;

  typedef struct packed {
    logic                      command;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } request_t;

  typedef struct packed {
    logic                      kind;
    logic signed [VALUE_W-1:0] value_res;
    logic [POS_W-1:0]          position;
    logic                      found;
    logic                      overflow;
    logic                      last_res;
  } answer_t;

  typedef enum int {MIX_WIDE, MIX_DUPS, MIX_EDGES, MIX_NARROW} value_mix_t;

  logic clk = 1'b0;
  logic rst;

  stbs_in_if  req_if();
  stbs_out_if ans_if();

  sort_then_binary_search #(.CAPACITY(CAPACITY)) u_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (req_if),
    .dout (ans_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and expectations
  request_t requests_pending[$];
  answer_t  answers_due[$];
  request_t on_bus;
  logic signed [VALUE_W-1:0] set_values[$];
  int       phase_items;

  // predictor state
  logic signed [VALUE_W-1:0] sorted_store[CAPACITY];
  int       stored_count;
  logic     set_is_sorted;
  logic     set_overflowed;

  // idling control
  int       send_idle_pct;
  int       recv_stall_pct;
  logic     holding_off;

  // bookkeeping
  int       mismatch_count;
  int       results_checked;
  int       requests_seen;
  int       sets_sorted;
  int       largest_set;
  int       overflow_sets;
  int       searches_seen;
  int       search_hits;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // advance the predictor by one accepted request and queue what it produces
  task automatic compute_answers(input request_t rq);
    answer_t a;
    logic signed [VALUE_W-1:0] key;
    logic signed [VALUE_W-1:0] v;
    int lo, hi, mid, j;
    requests_seen++;
    key = rq.value;
    if (rq.command == CMD_LOAD) begin
      if (set_is_sorted) begin
        stored_count   = 0;
        set_overflowed = 1'b0;
        set_is_sorted  = 1'b0;
      end
      if (stored_count < CAPACITY) begin
        sorted_store[stored_count] = key;
        stored_count++;
      end else begin
        set_overflowed = 1'b1;
      end
      if (rq.last) begin
        for (int i = 1; i < stored_count; i++) begin
          v = sorted_store[i];
          j = i;
          while (j > 0 && sorted_store[j-1] > v) begin
            sorted_store[j] = sorted_store[j-1];
            j--;
          end
          sorted_store[j] = v;
        end
        set_is_sorted = 1'b1;
        sets_sorted++;
        if (stored_count > largest_set) largest_set = stored_count;
        if (set_overflowed) overflow_sets++;
        for (int k = 0; k < stored_count; k++) begin
          a.kind      = KIND_ELEMENT;
          a.value_res = sorted_store[k];
          a.position  = POS_W'(k);
          a.found     = 1'b0;
          a.overflow  = set_overflowed;
          a.last_res  = (k == stored_count - 1);
          answers_due.push_back(a);
        end
      end
    end else begin
      searches_seen++;
      a.kind      = KIND_ANSWER;
      a.value_res = key;
      a.position  = '0;
      a.found     = 1'b0;
      a.overflow  = set_overflowed;
      a.last_res  = 1'b1;
      if (set_is_sorted && stored_count > 0) begin
        lo = 0;
        hi = stored_count - 1;
        while (lo <= hi && !a.found) begin
          mid = (lo + hi) / 2;
          if (sorted_store[mid] == key) begin
            a.found    = 1'b1;
            a.position = POS_W'(mid);
          end else if (key < sorted_store[mid]) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
      end
      if (a.found) search_hits++;
      answers_due.push_back(a);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) compute_answers(on_bus);
      if (!req_if.valid || req_if.ready) begin
        if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = requests_pending.pop_front();
          req_if.valid   <= 1'b1;
          req_if.command <= on_bus.command;
          req_if.value   <= on_bus.value;
          req_if.last    <= on_bus.last;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (rst || holding_off) begin
      ans_if.ready <= 1'b0;
    end else begin
      ans_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    answer_t want;
    if (!rst && ans_if.valid && ans_if.ready) begin
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value %0d pos %0d",
                                  ans_if.kind, ans_if.value_res, ans_if.position));
      end else begin
        want = answers_due.pop_front();
        results_checked++;
        if (ans_if.kind !== want.kind)
          report_mismatch($sformatf("kind got %b want %b", ans_if.kind, want.kind));
        if (ans_if.value_res !== want.value_res)
          report_mismatch($sformatf("value_res got %0d want %0d",
                                    ans_if.value_res, want.value_res));
        if (ans_if.position !== want.position)
          report_mismatch($sformatf("position got %0d want %0d (value %0d)",
                                    ans_if.position, want.position, want.value_res));
        if (ans_if.found !== want.found)
          report_mismatch($sformatf("found got %b want %b (key %0d)",
                                    ans_if.found, want.found, want.value_res));
        if (ans_if.overflow !== want.overflow)
          report_mismatch($sformatf("overflow got %b want %b",
                                    ans_if.overflow, want.overflow));
        if (ans_if.last_res !== want.last_res)
          report_mismatch($sformatf("last_res got %b want %b (pos %0d)",
                                    ans_if.last_res, want.last_res, want.position));
      end
    end
  end

  task automatic queue_request(input logic cmd, input logic signed [VALUE_W-1:0] v,
                               input logic is_last);
    request_t rq;
    rq.command = cmd;
    rq.value   = v;
    rq.last    = is_last;
    requests_pending.push_back(rq);
    phase_items++;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value(input value_mix_t mix);
    case (mix)
      MIX_DUPS:   return VALUE_W'(int'($urandom_range(8)) - 4);
      MIX_NARROW: return VALUE_W'(int'($urandom_range(2000)) - 1000);
      MIX_EDGES: begin
        case ($urandom_range(4))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          3:       return '1;
          default: return $urandom;
        endcase
      end
      default:    return $urandom;
    endcase
  endfunction

  // one set of loads; now and then a search slips in before the set is closed
  task automatic queue_set(input int size, input value_mix_t mix);
    logic signed [VALUE_W-1:0] v;
    set_values.delete();
    for (int i = 0; i < size; i++) begin
      v = pick_value(mix);
      set_values.push_back(v);
      queue_request(CMD_LOAD, v, i == size - 1);
      if (i > 0 && i < size - 1 && $urandom_range(99) < 4)
        queue_request(CMD_SEARCH, set_values[0], 1'($urandom_range(1)));
    end
  endtask

  task automatic queue_searches(input int count);
    logic signed [VALUE_W-1:0] key;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      key = set_values[$urandom_range(set_values.size() - 1)];
      if (r >= 55 && r < 70) key = key + ($urandom_range(1) ? 1 : -1);
      else if (r >= 70 && r < 85) key = $urandom;
      else if (r >= 85) key = pick_value(MIX_EDGES);
      queue_request(CMD_SEARCH, key, $urandom_range(99) < 20);
    end
  endtask

  task automatic queue_phase_stimulus(input int phase);
    int r, size;
    phase_items = 0;
    if (phase == 0) begin
      // search with nothing loaded, and with last set
      queue_request(CMD_SEARCH, '0, 1'b1);
      // set with both extremes and duplicates; a search before it is closed
      queue_request(CMD_LOAD, VAL_MAX, 1'b0);
      queue_request(CMD_SEARCH, VAL_MAX, 1'b0);
      queue_request(CMD_LOAD, VAL_MIN, 1'b0);
      queue_request(CMD_LOAD, '0, 1'b0);
      queue_request(CMD_LOAD, '1, 1'b0);
      queue_request(CMD_LOAD, 32'sd5, 1'b0);
      queue_request(CMD_LOAD, 32'sd5, 1'b0);
      queue_request(CMD_LOAD, 32'sd1, 1'b1);
      queue_request(CMD_SEARCH, VAL_MIN, 1'b0);
      queue_request(CMD_SEARCH, VAL_MAX, 1'b0);
      queue_request(CMD_SEARCH, 32'sd5, 1'b0);
      queue_request(CMD_SEARCH, 32'sd2, 1'b0);
      queue_request(CMD_SEARCH, -32'sd2, 1'b0);
      queue_request(CMD_SEARCH, '0, 1'b1);
      // single element set
      queue_request(CMD_LOAD, 32'sd42, 1'b1);
      queue_request(CMD_SEARCH, 32'sd42, 1'b0);
      queue_request(CMD_SEARCH, 32'sd41, 1'b0);
      queue_request(CMD_SEARCH, VAL_MIN, 1'b0);
      // all equal
      queue_request(CMD_LOAD, 32'sd7, 1'b0);
      queue_request(CMD_LOAD, 32'sd7, 1'b0);
      queue_request(CMD_LOAD, 32'sd7, 1'b1);
      queue_request(CMD_SEARCH, 32'sd7, 1'b0);
      // a full set
      queue_set(CAPACITY, MIX_WIDE);
      queue_searches(4);
    end else if (phase == 1) begin
      // overflowing set, searches may ask for dropped values
      queue_set(CAPACITY + 3, MIX_NARROW);
      queue_searches(6);
    end
    while (phase_items < PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 65) size = $urandom_range(8, 1);
      else if (r < 88) size = $urandom_range(24, 9);
      else if (r < 97) size = $urandom_range(CAPACITY, 25);
      else size = $urandom_range(CAPACITY + 6, CAPACITY + 1);
      queue_set(size, value_mix_t'($urandom_range(3)));
      queue_searches($urandom_range(5));
    end
  endtask

  task automatic hold_results(input int cycles);
    holding_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    holding_off <= 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.command = CMD_LOAD;
    req_if.value   = '0;
    req_if.last    = 1'b0;
    ans_if.ready   = 1'b0;
    holding_off    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stored_count   = 0;
    set_is_sorted  = 1'b0;
    set_overflowed = 1'b0;
    mismatch_count = 0;
    results_checked = 0;
    requests_seen  = 0;
    sets_sorted    = 0;
    largest_set    = 0;
    overflow_sets  = 0;
    searches_seen  = 0;
    search_hits    = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 56; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 56; end
        default: begin send_idle_pct <= 30; recv_stall_pct <= 30; end
      endcase
      // output held off long enough for the block to back up into its input
      if (phase == 0) begin
        fork
          hold_results(300);
        join_none
      end
      queue_phase_stimulus(phase);
      while (requests_pending.size() != 0 || req_if.valid || answers_due.size() != 0)
        @(posedge clk);
    end
    repeat (80) @(posedge clk);

    $display("covered %0d requests: %0d sets sorted (largest %0d, %0d overflowed)",
             requests_seen, sets_sorted, largest_set, overflow_sets);
    $display("%0d searches (%0d hits), %0d results checked, %0d mismatches",
             searches_seen, search_hits, results_checked, mismatch_count);
    if (mismatch_count == 0 && answers_due.size() == 0) begin
      $display("** sort_then_binary_search: PASSED **");
    end else begin
      $display("** sort_then_binary_search: FAILED **");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("timeout with %0d results still due", answers_due.size());
    $display("** sort_then_binary_search: FAILED **");
    $finish;
  end

endmodule

/* sort_then_binary_search.f */
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_in_if.sv
hw/rtl/stbs_out_if.sv
hw/rtl/stbs_mem.sv
hw/rtl/stbs_core.sv
hw/rtl/sort_then_binary_search.sv
tb/sv/tb_top.sv
